>>> rtl/fbma_pkg.sv
// Shared types and constants for the file block map allocator.
// Used by fbma_bit_find and the top level; depends on nothing.
package fbma_pkg;

  localparam int SLOT_W   = 4;
  localparam int BLK_W    = 4;
  localparam int START_W  = 20;
  localparam int PHYS_W   = 21;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int GRP_W    = 3;

  localparam logic [START_W-1:0] START_RESET = 20'd299;

  localparam int FILE_SLOTS_DEF      = 16;
  localparam int BLOCKS_PER_FILE_DEF = 16;
  localparam int BITMAP_BITS_DEF     = 4096;

  typedef enum logic [1:0] {
    ST_UNMAPPED = 2'd0,
    ST_EXISTING = 2'd1,
    ST_NEW      = 2'd2,
    ST_NOSPACE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0] file_slot;
    logic [BLK_W-1:0]  block_index;
    logic              create;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [PHYS_W-1:0] phys_block;
  } out_word_t;

  typedef struct packed {
    logic             done;
    logic [BIT_W-1:0] bit_idx;
  } find_rsp_t;

endpackage

>>> rtl/fbma_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the block map and the free bitmap; depends on nothing.
module fbma_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 21,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fbma_bit_find.sv
// Two-stage search for the lowest clear bit of a 64-bit bitmap word.
// Uses fbma_pkg; the word handed in must hold at least one clear bit.
module fbma_bit_find (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fbma_pkg::WORD_W-1:0] word,
  output fbma_pkg::find_rsp_t         rsp
);
  import fbma_pkg::*;

  localparam int GROUPS = WORD_W / 8;

  logic             s1_v_r;
  logic [GRP_W-1:0] grp_r;
  logic [7:0]       byte_r;
  logic [GRP_W-1:0] grp_nxt;
  logic [2:0]       bit_nxt;
  logic             done_r;
  logic [BIT_W-1:0] idx_r;

  // stage 1: pick the lowest byte that is not full
  always_comb begin
    grp_nxt = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (!(&word[g*8 +: 8])) begin
        grp_nxt = GRP_W'(g);
      end
    end
  end

  // stage 2: lowest clear bit inside that byte
  always_comb begin
    bit_nxt = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!byte_r[b]) begin
        bit_nxt = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= start;
      done_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      grp_r  <= grp_nxt;
      byte_r <= word[grp_nxt*8 +: 8];
    end
    if (s1_v_r) begin
      idx_r <= {grp_r, bit_nxt};
    end
  end

  assign rsp.done    = done_r;
  assign rsp.bit_idx = idx_r;

endmodule

>>> rtl/file_block_map_allocator.sv
// Top level of the file block map allocator: control sequencer, config register.
// Depends on fbma_pkg, fbma_ram (block map, free bitmap) and fbma_bit_find.
//
//  channel | direction | word         | accepted when
//  --------+-----------+--------------+------------------------
//  in_     | input     | in_word_t    | in_valid & in_ready
//  out_    | output    | out_word_t   | out_valid & out_ready
//  cfg_    | input     | data_start   | cfg_valid & cfg_ready (always ready)
//
// Flow: a lookup, an out-of-range word, or a create whose entry and its file's block 0
// are both mapped passes the entry read, the block 0 read and the check to the output
// stage, then the sequencer returns to idle for the next word. Any other create
// reads the free bitmap memory one 64-bit word a cycle until a word with a clear
// bit is found, then the two-stage bit finder and a write-back state follow. A
// full bitmap, or a clear bit past the last data block, answers no-space.
// Reset: a clearing pass writes zeros through every address of both memories;
// in_ready stays low until it ends, config writes are taken throughout.
// Stalls: one word is processed at a time; a finished result parks in the
// output register and the next input word is accepted while it waits.
module file_block_map_allocator #(
  parameter int FILE_SLOTS      = fbma_pkg::FILE_SLOTS_DEF,
  parameter int BLOCKS_PER_FILE = fbma_pkg::BLOCKS_PER_FILE_DEF,
  parameter int BITMAP_BITS     = fbma_pkg::BITMAP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fbma_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fbma_pkg::out_word_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fbma_pkg::START_W-1:0] cfg_data
);
  import fbma_pkg::*;

  localparam int MAP_DEPTH = FILE_SLOTS * BLOCKS_PER_FILE;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int BM_WORDS  = (BITMAP_BITS + WORD_W - 1) / WORD_W;
  localparam int BM_AW     = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
  localparam int SCAN_W    = $clog2(BM_WORDS + 1);
  localparam int IDX_W     = BM_AW + BIT_W;
  localparam int CLR_DEPTH = (MAP_DEPTH > BM_WORDS) ? MAP_DEPTH : BM_WORDS;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_RD_ENT = 9'b000000100,
    S_RD_B0  = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_FIND   = 9'b001000000,
    S_ALLOC  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CLR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [START_W-1:0]  data_start_r;
  in_word_t            req_r, req_nxt;
  logic [PHYS_W-1:0]   phys_r, phys_nxt;
  out_word_t           rsp_r, rsp_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;
  logic [SCAN_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [BM_AW-1:0]    chk_w_r, chk_w_nxt;
  logic [BM_AW-1:0]    word_idx_r, word_idx_nxt;
  logic [WORD_W-1:0]   bm_word_r, bm_word_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // memory ports
  logic                map_we, map_re;
  logic [MAP_AW-1:0]   map_waddr, map_raddr;
  logic [PHYS_W-1:0]   map_wdata, map_rdata;
  logic                bm_we, bm_re;
  logic [BM_AW-1:0]    bm_waddr, bm_raddr;
  logic [WORD_W-1:0]   bm_wdata, bm_rdata;

  logic                find_start;
  find_rsp_t           find_rsp;

  logic                in_range;
  logic [MAP_AW-1:0]   ent_addr, base_addr;
  logic [PHYS_W-1:0]   phys_new;
  logic [IDX_W-1:0]    find_idx;
  logic                scan_issue;

  fbma_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (PHYS_W),
    .AW    (MAP_AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  fbma_ram #(
    .DEPTH (BM_WORDS),
    .WIDTH (WORD_W),
    .AW    (BM_AW)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  fbma_bit_find u_find (
    .clk   (clk),
    .rst_n (rst_n),
    .start (find_start),
    .word  (bm_rdata),
    .rsp   (find_rsp)
  );

  // Request decode: range check and map addresses of the entry and block 0.
  assign in_range  = (32'(req_r.file_slot) < 32'(FILE_SLOTS)) &&
                     (32'(req_r.block_index) < 32'(BLOCKS_PER_FILE));
  assign base_addr = MAP_AW'(32'(req_r.file_slot) * 32'(BLOCKS_PER_FILE));
  assign ent_addr  = MAP_AW'(32'(req_r.file_slot) * 32'(BLOCKS_PER_FILE) +
                             32'(req_r.block_index));
  // The sum wraps to the physical block width.
  assign phys_new  = PHYS_W'(data_start_r) + PHYS_W'(idx_r);
  assign find_idx  = {word_idx_r, find_rsp.bit_idx};
  assign scan_issue = (32'(scan_cnt_r) < 32'(BM_WORDS));

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory port control.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = ent_addr;
    map_wdata = phys_new;
    map_re    = 1'b0;
    map_raddr = ent_addr;
    bm_we     = 1'b0;
    bm_waddr  = word_idx_r;
    bm_wdata  = bm_word_r | (WORD_W'(1) << bit_r);
    bm_re     = 1'b0;
    bm_raddr  = BM_AW'(scan_cnt_r);
    case (state_r)
      S_CLEAR: begin
        // sweep zeros through both memories
        map_we    = (32'(clr_cnt_r) < 32'(MAP_DEPTH));
        map_waddr = MAP_AW'(clr_cnt_r);
        map_wdata = '0;
        bm_we     = (32'(clr_cnt_r) < 32'(BM_WORDS));
        bm_waddr  = BM_AW'(clr_cnt_r);
        bm_wdata  = '0;
      end
      S_RD_ENT: begin
        map_re    = 1'b1;
      end
      S_RD_B0: begin
        map_re    = 1'b1;
        map_raddr = base_addr;
      end
      S_SCAN: begin
        bm_re     = scan_issue;
      end
      S_ALLOC: begin
        // mark the bit used and store the new mapping
        map_we    = 1'b1;
        bm_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    phys_nxt      = phys_r;
    rsp_nxt       = rsp_r;
    scan_cnt_nxt  = scan_cnt_r;
    chk_v_nxt     = chk_v_r;
    chk_w_nxt     = chk_w_r;
    word_idx_nxt  = word_idx_r;
    bm_word_nxt   = bm_word_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    find_start    = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_RD_ENT;
        end
      end
      S_RD_ENT: begin
        state_nxt = S_RD_B0;
      end
      S_RD_B0: begin
        // entry data arrives; block 0 read is in flight
        phys_nxt  = map_rdata;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_OUT;
        rsp_nxt   = '{status: ST_UNMAPPED, phys_block: '0};
        if (in_range) begin
          if (!req_r.create || (map_rdata != '0 && phys_r != '0)) begin
            if (phys_r != '0) begin
              rsp_nxt = '{status: ST_EXISTING, phys_block: phys_r};
            end
          end else begin
            scan_cnt_nxt = '0;
            chk_v_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one word read a cycle, check the word read the cycle before
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + SCAN_W'(1);
        end
        chk_v_nxt = scan_issue;
        chk_w_nxt = BM_AW'(scan_cnt_r);
        if (chk_v_r) begin
          if (bm_rdata != {WORD_W{1'b1}}) begin
            bm_word_nxt  = bm_rdata;
            word_idx_nxt = chk_w_r;
            find_start   = 1'b1;
            state_nxt    = S_FIND;
          end else if (chk_w_r == BM_AW'(BM_WORDS - 1)) begin
            rsp_nxt   = '{status: ST_NOSPACE, phys_block: '0};
            state_nxt = S_OUT;
          end
        end
      end
      S_FIND: begin
        if (find_rsp.done) begin
          bit_nxt = find_rsp.bit_idx;
          idx_nxt = find_idx;
          // a clear bit past the last data block means the bitmap is full
          if ({1'b0, find_idx} >= (IDX_W + 1)'(BITMAP_BITS)) begin
            rsp_nxt   = '{status: ST_NOSPACE, phys_block: '0};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        rsp_nxt   = '{status: ST_NEW, phys_block: phys_new};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rsp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      chk_v_r      <= 1'b0;
      scan_cnt_r   <= '0;
      data_start_r <= START_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        data_start_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    phys_r     <= phys_nxt;
    rsp_r      <= rsp_nxt;
    out_data_r <= out_data_nxt;
    chk_w_r    <= chk_w_nxt;
    word_idx_r <= word_idx_nxt;
    bm_word_r  <= bm_word_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
  end

  // An accepted word always starts with the entry read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_RD_ENT))
    else $error("accepted word did not start the map read");

  // Unmapped and no-space results carry a zero block number.
  a_zero_phys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_UNMAPPED ||
                     out_data_r.status == ST_NOSPACE))
    |-> (out_data_r.phys_block == '0))
    else $error("nonzero block number with unmapped or no-space status");

  // The allocated bit must have been free in the word being written back.
  a_bit_was_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> !bm_word_r[bit_r])
    else $error("allocation reused a bit already marked used");

  // The finder only answers while the sequencer waits for it.
  a_find_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    find_rsp.done |-> (state_r == S_FIND))
    else $error("bit finder answered outside the find state");

endmodule
